[rtl/core/udp_ipv4_frame_builder_assert.svh]
// Assertion macros for the UDP/IPv4 frame builder.
`ifndef UDP_IPV4_FRAME_BUILDER_ASSERT_SVH
`define UDP_IPV4_FRAME_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define UFB_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UFB_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UFB_ASSERT_IMPL(label, clk, rst, prop, msg)
`define UFB_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/core/ufb_pkg.sv]
// ---------------------------------------------------------------------------
// ufb_pkg
// Shared types and constants of the UDP/IPv4 frame builder.
// ---------------------------------------------------------------------------
package ufb_pkg;
   localparam int FRAME_BYTES = 512;
   localparam int PTR_W       = $clog2(FRAME_BYTES + 1);
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int WORD_W      = ADDR_W - 3;
   localparam int HDR_BYTES   = 42;

   localparam logic [1:0] CSR_DST_MAC = 2'd0;
   localparam logic [1:0] CSR_SRC_MAC = 2'd1;
   localparam logic [1:0] CSR_IP_ID   = 2'd2;
   localparam logic [1:0] CSR_IP_TTL  = 2'd3;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_CHECKSUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take_word;
      logic first_word;
      logic start_sum;
      logic clear_frame;
   } cmd_type;

   typedef struct packed {
      logic             word_last;
      logic [WORD_W:0]  word_count;
   } status_type;
endpackage

[rtl/core/ufb_stream_if.sv]
// ---------------------------------------------------------------------------
// ufb_stream_if
// Valid/ready channel with a generic payload.
// ---------------------------------------------------------------------------
interface ufb_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/ufb_ram.sv]
// ---------------------------------------------------------------------------
// ufb_ram
// Generic single-port write, one-port registered read RAM.
// ---------------------------------------------------------------------------
module ufb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/core/ufb_ctrl.sv]
// ---------------------------------------------------------------------------
// ufb_ctrl
// Sequencer: collect payload, fold checksum, emit frame words.
// ---------------------------------------------------------------------------
module ufb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_last,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [ufb_pkg::WORD_W-1:0] rd_word,
   output logic                   out_last,
   input  ufb_pkg::status_type    status,
   output ufb_pkg::cmd_type       cmd
);
   ufb_pkg::state_type state_ff, state_in;
   logic first_ff, first_in;
   logic [ufb_pkg::WORD_W:0] sent_ff, sent_in;   // words delivered
   logic ov_ff, ov_in;                          // output valid
   logic fire_in, fire_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ufb_pkg::ST_COLLECT;
         first_ff <= 1'b1;
         sent_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         sent_ff  <= sent_in;
         ov_ff    <= ov_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      sent_in  = sent_ff;
      ov_in    = ov_ff;
      in_ready = 1'b0;
      cmd      = '0;
      fire_in  = 1'b0;
      fire_out = ov_ff && out_ready;
      case (state_ff)
         ufb_pkg::ST_COLLECT: begin
            in_ready = 1'b1;
            fire_in  = in_valid;
            cmd.take_word  = fire_in;
            cmd.first_word = fire_in && first_ff;
            if (fire_in) begin
               first_in = in_last;
               if (in_last) begin
                  state_in = ufb_pkg::ST_CHECKSUM;
               end
            end
         end
         ufb_pkg::ST_CHECKSUM: begin
            // the checksum is registered this cycle; address word 0
            cmd.start_sum = 1'b1;
            sent_in  = '0;
            ov_in    = 1'b1;
            state_in = ufb_pkg::ST_EMIT;
         end
         ufb_pkg::ST_EMIT: begin
            // advance on each transaction; the read address follows sent_in
            if (fire_out) begin
               sent_in = sent_ff + 1'b1;
               if (sent_ff + 1'b1 == status.word_count) begin
                  cmd.clear_frame = 1'b1;
                  ov_in    = 1'b0;
                  state_in = ufb_pkg::ST_COLLECT;
               end
            end
         end
         default: state_in = ufb_pkg::ST_COLLECT;
      endcase
   end

   assign rd_word   = sent_in[ufb_pkg::WORD_W-1:0];
   assign out_valid = ov_ff;
   assign out_last  = (sent_ff + 1'b1 == status.word_count);
endmodule

[rtl/core/ufb_datapath.sv]
// ---------------------------------------------------------------------------
// ufb_datapath
// Byte packing, header assembly, checksum and frame store.
// ---------------------------------------------------------------------------
module ufb_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  ufb_pkg::cmd_type        cmd,
   output ufb_pkg::status_type     status,
   input  logic [63:0]             in_data,
   input  logic [7:0]              in_keep,
   input  logic [31:0]             in_sip,
   input  logic [15:0]             in_sport,
   input  logic [31:0]             in_dip,
   input  logic [15:0]             in_dport,
   input  logic                    csr_we,
   input  logic [1:0]              csr_idx,
   input  logic [47:0]             csr_data,
   input  logic [ufb_pkg::WORD_W-1:0] rd_word,
   input  logic                    out_last,
   output logic [63:0]             out_data,
   output logic [7:0]              out_keep,
   output logic [9:0]              out_bytes,
   output logic                    out_ovf
);
   localparam int PW = ufb_pkg::PTR_W;
   localparam int NB = ufb_pkg::FRAME_BYTES / 8;

   logic [47:0] dmac_ff, smac_ff;
   logic [15:0] ident_ff;
   logic [7:0]  ttl_ff;
   logic [31:0] sip_ff, dip_ff;
   logic [15:0] sport_ff, dport_ff;
   logic [PW-1:0] wp_ff, wp_in;
   logic ovf_ff, ovf_in;
   logic [15:0] csum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dmac_ff <= '0; smac_ff <= '0; ident_ff <= '0; ttl_ff <= 8'd64;
         sip_ff <= '0; dip_ff <= '0; sport_ff <= '0; dport_ff <= '0;
         wp_ff <= PW'(ufb_pkg::HDR_BYTES);
         ovf_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               ufb_pkg::CSR_DST_MAC: dmac_ff  <= csr_data;
               ufb_pkg::CSR_SRC_MAC: smac_ff  <= csr_data;
               ufb_pkg::CSR_IP_ID:   ident_ff <= csr_data[15:0];
               ufb_pkg::CSR_IP_TTL:  ttl_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
         if (cmd.first_word) begin
            sip_ff <= in_sip; dip_ff <= in_dip;
            sport_ff <= in_sport; dport_ff <= in_dport;
         end
         wp_ff  <= wp_in;
         ovf_ff <= ovf_in;
      end
   end

   // Pack kept lanes: one byte lane per RAM bank, bank = address mod 8.
   logic [PW-1:0] base;
   logic          base_ovf;
   logic [7:0]    bwe;
   logic [7:0]    bdat [8];
   logic [ufb_pkg::ADDR_W-1:0] baddr [8];
   logic [3:0]    rank;
   logic [PW-1:0] pos;

   always_comb begin
      base     = cmd.first_word ? PW'(ufb_pkg::HDR_BYTES) : wp_ff;
      base_ovf = cmd.first_word ? 1'b0 : ovf_ff;
      bwe      = '0;
      rank     = '0;
      pos      = '0;
      for (int b = 0; b < 8; b++) begin
         bdat[b]  = '0;
         baddr[b] = '0;
      end
      for (int i = 0; i < 8; i++) begin
         if (in_keep[i]) begin
            pos = base + PW'(rank);
            if (pos < PW'(ufb_pkg::FRAME_BYTES)) begin
               bwe[pos[2:0]]   = cmd.take_word;
               bdat[pos[2:0]]  = in_data[8*i +: 8];
               baddr[pos[2:0]] = pos[ufb_pkg::ADDR_W-1:0];
               rank = rank + 4'd1;
            end else begin
               base_ovf = 1'b1;
            end
         end
      end
      wp_in  = wp_ff;
      ovf_in = ovf_ff;
      if (cmd.take_word) begin
         wp_in  = base + PW'(rank);
         ovf_in = base_ovf;
      end
      if (cmd.clear_frame) begin
         wp_in  = PW'(ufb_pkg::HDR_BYTES);
         ovf_in = 1'b0;
      end
   end

   // Header bytes in frame order.
   logic [15:0] ip_len, udp_len;
   logic [7:0]  hdr [42];
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;
   always_comb begin
      ip_len  = 16'(wp_ff) - 16'd14;
      udp_len = 16'(wp_ff) - 16'd34;
      sum = 20'h4500 + 20'(ip_len) + 20'(ident_ff) + 20'h4000
          + 20'({ttl_ff, 8'h11}) + 20'(sip_ff[31:16]) + 20'(sip_ff[15:0])
          + 20'(dip_ff[31:16]) + 20'(dip_ff[15:0]);
      fold1 = 17'(sum[19:16]) + 17'(sum[15:0]);
      fold2 = 16'(fold1[16]) + fold1[15:0];
      for (int i = 0; i < 6; i++) begin
         hdr[i]     = dmac_ff[40-8*i +: 8];
         hdr[6+i]   = smac_ff[40-8*i +: 8];
      end
      hdr[12] = 8'h08; hdr[13] = 8'h00; hdr[14] = 8'h45; hdr[15] = 8'h00;
      hdr[16] = ip_len[15:8];  hdr[17] = ip_len[7:0];
      hdr[18] = ident_ff[15:8]; hdr[19] = ident_ff[7:0];
      hdr[20] = 8'h40; hdr[21] = 8'h00; hdr[22] = ttl_ff; hdr[23] = 8'h11;
      hdr[24] = csum_ff[15:8]; hdr[25] = csum_ff[7:0];
      hdr[26] = sip_ff[31:24]; hdr[27] = sip_ff[23:16];
      hdr[28] = sip_ff[15:8];  hdr[29] = sip_ff[7:0];
      hdr[30] = dip_ff[31:24]; hdr[31] = dip_ff[23:16];
      hdr[32] = dip_ff[15:8];  hdr[33] = dip_ff[7:0];
      hdr[34] = sport_ff[15:8]; hdr[35] = sport_ff[7:0];
      hdr[36] = dport_ff[15:8]; hdr[37] = dport_ff[7:0];
      hdr[38] = udp_len[15:8]; hdr[39] = udp_len[7:0];
      hdr[40] = 8'h00; hdr[41] = 8'h00;
   end

   // Checksum registered on the last payload word's following cycle.
   always_ff @(posedge clock) begin
      if (cmd.start_sum) csum_ff <= ~fold2;
   end

   // Read side: header words come from registers, payload from the banks.
   logic [7:0] rd_b [8];
   logic [ufb_pkg::WORD_W-1:0] rw_ff;
   always_ff @(posedge clock) begin
      rw_ff <= rd_word;
   end

   for (genvar b = 0; b < 8; b++) begin : g_bank
      ufb_ram #(.WIDTH(8), .DEPTH(NB)) u_ram (
         .clock   (clock),
         .wr_en   (bwe[b]),
         .wr_addr (baddr[b][ufb_pkg::ADDR_W-1:3]),
         .wr_data (bdat[b]),
         .rd_addr (rd_word),
         .rd_data (rd_b[b])
      );
   end

   logic [PW-1:0] bpos;
   always_comb begin
      out_data = '0;
      out_keep = '0;
      bpos     = '0;
      for (int i = 0; i < 8; i++) begin
         bpos = PW'({rw_ff, 3'(i)});
         if (bpos < wp_ff) begin
            out_keep[i] = 1'b1;
            out_data[8*i +: 8] = (bpos < PW'(ufb_pkg::HDR_BYTES))
                               ? hdr[bpos[5:0]] : rd_b[i];
         end
      end
   end
   assign out_bytes = out_last ? 10'(wp_ff) : 10'd0;
   assign out_ovf   = out_last & ovf_ff;
   assign status.word_last  = out_last;
   assign status.word_count = (ufb_pkg::WORD_W + 1)'((wp_ff + PW'(7)) >> 3);
endmodule

[rtl/core/udp_ipv4_frame_builder.sv]
// ---------------------------------------------------------------------------
// udp_ipv4_frame_builder
// Wraps UDP payload words into Ethernet/IPv4/UDP frames.
// ---------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | payload word, keep, last, socket metadata
//  rsp     | out | frame word, keep, last, byte count, overflow flag
//  csr     | in  | register index and write data
//
// Payload words are accepted back to back; after the last word the checksum
// state registers the checksum, then frame words are emitted: the banked store
// is read at the next word's address ahead of the output, so frame words leave
// back to back while rsp is ready.
// Synchronous reset clears control; the store needs no clearing.
// rsp stalls hold the emit sequencer; req is held off until the frame is out.
`include "udp_ipv4_frame_builder_assert.svh"
module udp_ipv4_frame_builder (
   input logic clock,
   input logic reset,
   ufb_stream_if.sink   req,
   ufb_stream_if.source rsp,
   ufb_stream_if.sink   csr
);
   ufb_pkg::cmd_type    cmd;
   ufb_pkg::status_type status;
   logic [ufb_pkg::WORD_W-1:0] rd_word;
   logic out_last;

   // configuration always taken
   assign csr.ready = 1'b1;

   ufb_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_last(req.payload.payload_last),
      .out_ready(rsp.ready), .out_valid(rsp.valid), .rd_word(rd_word),
      .out_last(out_last), .status(status), .cmd(cmd)
   );

   ufb_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_data(req.payload.payload_data), .in_keep(req.payload.payload_keep),
      .in_sip(req.payload.source_ip), .in_sport(req.payload.source_port),
      .in_dip(req.payload.dest_ip), .in_dport(req.payload.dest_port),
      .csr_we(csr.valid), .csr_idx(csr.payload.index[1:0]),
      .csr_data(csr.payload.data[47:0]),
      .rd_word(rd_word), .out_last(out_last),
      .out_data(rsp.payload.frame_data), .out_keep(rsp.payload.frame_keep),
      .out_bytes(rsp.payload.frame_bytes), .out_ovf(rsp.payload.payload_overflow)
   );
   assign rsp.payload.frame_last = rsp.valid & out_last;

   // hold off input while a frame is emitted
   `UFB_ASSERT_IMPL(a_no_req_during_emit, clock, reset,
      rsp.valid |-> !req.ready, "req ready during emit")
   `UFB_ASSERT_IMPL(a_keep_full_midframe, clock, reset,
      (rsp.valid && !rsp.payload.frame_last) |-> (rsp.payload.frame_keep == 8'hFF),
      "partial keep mid-frame")
endmodule
